// ----- design/her_pkg.sv -----
package her_pkg;

    localparam int MAX_NAME_BYTES = 32;
    localparam int LEN_W  = $clog2(MAX_NAME_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_NAME_BYTES);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;

    // Keys below ENT_COUNT are replaced entities; the rest are passed verbatim.
    localparam int ENT_COUNT  = 17;
    localparam int VERB_COUNT = 5;
    localparam int KEY_COUNT  = ENT_COUNT + VERB_COUNT;
    localparam int KEY_CHARS  = 6;
    localparam int ENT_W      = $clog2(ENT_COUNT);

    localparam logic [8*KEY_CHARS-1:0] KEY_NAME [KEY_COUNT] = '{
        "lsqb  ", "rsqb  ", "nbsp  ", "ndash ", "mdash ", "hellip",
        "bull  ", "dagger", "sect  ", "para  ", "prime ", "Prime ",
        "times ", "minus ", "middot", "lrm   ", "rlm   ",
        "amp   ", "lt    ", "gt    ", "quot  ", "apos  "
    };

    localparam logic [2:0] KEY_LEN [KEY_COUNT] = '{
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd4, 3'd6, 3'd4, 3'd4, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd6, 3'd3, 3'd3,
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4
    };

    localparam logic [23:0] ENT_BYTES [ENT_COUNT] = '{
        24'h5B0000, 24'h5D0000, 24'h200000, 24'hE28093, 24'hE28094,
        24'hE280A6, 24'hE280A2, 24'hE280A0, 24'hC2A700, 24'hC2B600,
        24'hE280B2, 24'hE280B3, 24'hC39700, 24'hE28892, 24'hC2B700,
        24'h000000, 24'h000000
    };

    localparam logic [1:0] ENT_BLEN [ENT_COUNT] = '{
        2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0
    };

    // Output bytes of one input, in order: '&', held name bytes, entity bytes, tail byte.
    typedef struct packed {
        logic              amp;
        logic [LEN_W-1:0]  nidx;
        logic [LEN_W-1:0]  ncnt;
        logic [ENT_W-1:0]  eid;
        logic [1:0]        epos;
        logic [1:0]        elen;
        logic              tail;
        logic [7:0]        tail_byte;
    } plan_t;

    typedef struct packed {
        logic              is_mem;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } token_t;

    localparam plan_t PLAN_EMPTY = '0;

    function automatic logic [7:0] key_char(input int unsigned k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (int'(pos) < KEY_CHARS)
        begin
            c = KEY_NAME[k][8*(KEY_CHARS-1-int'(pos)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] ent_byte(input logic [ENT_W-1:0] eid, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (int'(eid) < ENT_COUNT && pos < 2'd3)
        begin
            c = ENT_BYTES[eid][8*(2-int'(pos)) +: 8];
        end
        return c;
    endfunction

    function automatic logic plan_empty(input plan_t p);
        return !p.amp && (p.nidx >= p.ncnt) && (p.epos >= p.elen) && !p.tail;
    endfunction

    function automatic token_t plan_token(input plan_t p);
        token_t t;
        t.is_mem = 1'b0;
        t.addr   = p.nidx[ADDR_W-1:0];
        t.data   = CH_AMP;
        if (p.amp)
        begin
            t.data = CH_AMP;
        end
        else if (p.nidx < p.ncnt)
        begin
            t.is_mem = 1'b1;
        end
        else if (p.epos < p.elen)
        begin
            t.data = ent_byte(p.eid, p.epos);
        end
        else
        begin
            t.data = p.tail_byte;
        end
        return t;
    endfunction

    function automatic plan_t plan_rest(input plan_t p);
        plan_t r;
        r = p;
        if (p.amp)
        begin
            r.amp = 1'b0;
        end
        else if (p.nidx < p.ncnt)
        begin
            r.nidx = LEN_W'(p.nidx + 1'b1);
        end
        else if (p.epos < p.elen)
        begin
            r.epos = 2'(p.epos + 1'b1);
        end
        else
        begin
            r.tail = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- design/her_name_ram.sv -----
module her_name_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [her_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [her_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import her_pkg::*;

    logic [7:0] mem [MAX_NAME_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/her_parse.sv -----
module her_parse (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 in_byte,
    input  logic                       stream_end,
    output her_pkg::plan_t             plan,
    output logic                       wr_en,
    output logic [her_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                 wr_data
);
    import her_pkg::*;

    logic                 in_entity_reg, in_entity_next;
    logic [LEN_W-1:0]     name_length_reg, name_length_next;
    logic [KEY_COUNT-1:0] prefix_reg, prefix_next;
    logic                 hash_reg, hash_next;

    logic [KEY_COUNT-1:0] key_hit;
    logic [KEY_COUNT-1:0] key_step;
    logic                 verbatim;
    logic                 ent_found;
    logic [ENT_W-1:0]     ent_id;
    logic                 malformed;
    logic                 store;
    logic [2:0]           pos;
    plan_t                plan_c;

    assign pos = (name_length_reg < LEN_W'(KEY_CHARS)) ? name_length_reg[2:0] : 3'd0;

    always_comb
    begin
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            key_hit[k]  = prefix_reg[k] && (name_length_reg == LEN_W'(KEY_LEN[k]));
            key_step[k] = prefix_reg[k] && (name_length_reg < LEN_W'(KEY_LEN[k]))
                          && (key_char(k, pos) == in_byte);
        end
        ent_found = 1'b0;
        ent_id    = '0;
        for (int k = ENT_COUNT - 1; k >= 0; k--)
        begin
            if (key_hit[k])
            begin
                ent_found = 1'b1;
                ent_id    = ENT_W'(k);
            end
        end
        verbatim = hash_reg || (|key_hit[KEY_COUNT-1:ENT_COUNT]);
    end

    assign malformed = (in_byte == CH_AMP) || (in_byte == CH_LT)
                       || (name_length_reg >= LEN_W'(MAX_NAME_BYTES));
    assign store = in_entity_reg && (in_byte != CH_SEMI) && !malformed;

    always_comb
    begin
        plan_c           = PLAN_EMPTY;
        in_entity_next   = in_entity_reg;
        name_length_next = name_length_reg;
        prefix_next      = prefix_reg;
        hash_next        = hash_reg;
        if (!in_entity_reg)
        begin
            if (in_byte == CH_AMP)
            begin
                in_entity_next   = !stream_end;
                name_length_next = '0;
                prefix_next      = '1;
                hash_next        = 1'b0;
                plan_c.amp       = stream_end;
            end
            else
            begin
                plan_c.tail      = 1'b1;
                plan_c.tail_byte = in_byte;
            end
        end
        else if (in_byte == CH_SEMI)
        begin
            in_entity_next   = 1'b0;
            name_length_next = '0;
            if (verbatim)
            begin
                plan_c.amp       = 1'b1;
                plan_c.ncnt      = name_length_reg;
                plan_c.tail      = 1'b1;
                plan_c.tail_byte = CH_SEMI;
            end
            else if (ent_found)
            begin
                plan_c.eid  = ent_id;
                plan_c.elen = ENT_BLEN[ent_id];
            end
        end
        else if (malformed)
        begin
            plan_c.amp       = 1'b1;
            plan_c.ncnt      = name_length_reg;
            name_length_next = '0;
            prefix_next      = '1;
            hash_next        = 1'b0;
            if (in_byte == CH_AMP)
            begin
                in_entity_next   = !stream_end;
                plan_c.tail      = stream_end;
                plan_c.tail_byte = CH_AMP;
            end
            else
            begin
                in_entity_next   = 1'b0;
                plan_c.tail      = 1'b1;
                plan_c.tail_byte = in_byte;
            end
        end
        else
        begin
            name_length_next = LEN_W'(name_length_reg + 1'b1);
            prefix_next      = key_step;
            hash_next        = (name_length_reg == '0) ? (in_byte == CH_HASH) : hash_reg;
            if (stream_end)
            begin
                in_entity_next   = 1'b0;
                name_length_next = '0;
                plan_c.amp       = 1'b1;
                plan_c.ncnt      = LEN_W'(name_length_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg   <= 1'b0;
            name_length_reg <= '0;
            prefix_reg      <= '1;
            hash_reg        <= 1'b0;
        end
        else if (accept)
        begin
            in_entity_reg   <= in_entity_next;
            name_length_reg <= name_length_next;
            prefix_reg      <= prefix_next;
            hash_reg        <= hash_next;
        end
    end

    assign plan    = plan_c;
    assign wr_en   = accept && store;
    assign wr_addr = name_length_reg[ADDR_W-1:0];
    assign wr_data = in_byte;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        name_length_reg <= LEN_W'(MAX_NAME_BYTES))
        else $error("held name length exceeds the store depth");

    a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
        !in_entity_reg |-> name_length_reg == '0)
        else $error("name bytes held while no entity is open");

endmodule

// ----- design/her_replay.sv -----
module her_replay (
    input  logic                       clk,
    input  logic                       rst_n,
    input  her_pkg::plan_t             plan_in,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic                       m_last,
    output logic                       m_is_mem,
    output logic [7:0]                 m_byte,
    output logic                       rd_en,
    output logic [her_pkg::ADDR_W-1:0] rd_addr
);
    import her_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } state_t;

    state_t     state_reg;
    plan_t      plan_reg;
    logic       m_valid_reg;
    logic       out_last_reg;
    logic       out_is_mem_reg;
    logic [7:0] out_byte_reg;

    logic   slot_free;
    logic   accept;
    logic   issue;
    plan_t  src_plan;
    plan_t  rest;
    token_t tok;
    logic   rest_empty;

    assign slot_free  = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && slot_free;
    assign accept     = s_ready && s_valid;
    assign src_plan   = (state_reg == ST_IDLE) ? plan_in : plan_reg;
    assign tok        = plan_token(src_plan);
    assign rest       = plan_rest(src_plan);
    assign rest_empty = plan_empty(rest);
    assign issue      = slot_free && !plan_empty(src_plan)
                        && ((state_reg == ST_REPLAY) || s_valid);
    assign rd_en      = issue && tok.is_mem;
    assign rd_addr    = tok.addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            plan_reg       <= PLAN_EMPTY;
            m_valid_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
            out_is_mem_reg <= 1'b0;
            out_byte_reg   <= 8'h00;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !plan_empty(plan_in) && !rest_empty)
                    begin
                        state_reg <= ST_REPLAY;
                        plan_reg  <= rest;
                    end
                end
                ST_REPLAY:
                begin
                    if (slot_free)
                    begin
                        plan_reg <= rest;
                        if (rest_empty)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (issue)
            begin
                m_valid_reg    <= 1'b1;
                out_last_reg   <= rest_empty;
                out_is_mem_reg <= tok.is_mem;
                out_byte_reg   <= tok.data;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_last   = out_last_reg;
    assign m_is_mem = out_is_mem_reg;
    assign m_byte   = out_byte_reg;

    a_replay_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPLAY |-> !plan_empty(plan_reg))
        else $error("replay state with nothing left to send");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        issue && rest_empty |=> state_reg == ST_IDLE)
        else $error("final transfer of an input not followed by idle");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPLAY |-> !s_ready)
        else $error("input taken while a replay is in progress");

endmodule

// ----- design/html_entity_resolver.sv -----
// Latency: the first output byte of an input is valid the cycle after that input's transfer.
// Throughput: while the output accepts, plain text flows at one byte per cycle and a replay of
// held name bytes reads the name store once per cycle; no input is taken while a replay runs.
// Reset: rst_n is asynchronous and active low; it closes any open entity and empties the output.
// The name store is not cleared; only bytes written since the entity opened are ever read.
module html_entity_resolver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tlast,   // stream_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast    // run_last
);
    import her_pkg::*;

    plan_t             plan;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              out_is_mem;
    logic [7:0]        out_byte;

    assign accept = s_axis_tvalid && s_axis_tready;

    her_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .stream_end (s_axis_tlast),
        .plan       (plan),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    her_name_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    her_replay u_replay (
        .clk      (clk),
        .rst_n    (rst_n),
        .plan_in  (plan),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_last   (m_axis_tlast),
        .m_is_mem (out_is_mem),
        .m_byte   (out_byte),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    assign m_axis_tdata = out_is_mem ? rd_data : out_byte;

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import her_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 60;
    localparam int TABLE_ROWS  = 22;
    localparam int REPLACED    = 17;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int send_idle_pct;
    int recv_stall_pct;
    int n_in;
    int n_out;
    int mismatches;
    int idle_cycles;

    logic [7:0] held_name [MAX_NAME_BYTES];
    int         held_len;
    bit         entity_open;
    logic [7:0] step_bytes [$];
    out_beat_t  expected_beats [$];
    out_beat_t  want;

    html_entity_resolver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Rows below REPLACED are substituted; the remaining rows pass verbatim.
    function automatic void entity_row(input int k, output logic [47:0] nm, output int nl,
                                       output logic [23:0] rb, output int rn);
        rb = 24'h0;
        rn = 0;
        case (k)
            0:  begin nm = "lsqb";   nl = 4; rb = 24'h5B;     rn = 1; end
            1:  begin nm = "rsqb";   nl = 4; rb = 24'h5D;     rn = 1; end
            2:  begin nm = "nbsp";   nl = 4; rb = 24'h20;     rn = 1; end
            3:  begin nm = "ndash";  nl = 5; rb = 24'hE28093; rn = 3; end
            4:  begin nm = "mdash";  nl = 5; rb = 24'hE28094; rn = 3; end
            5:  begin nm = "hellip"; nl = 6; rb = 24'hE280A6; rn = 3; end
            6:  begin nm = "bull";   nl = 4; rb = 24'hE280A2; rn = 3; end
            7:  begin nm = "dagger"; nl = 6; rb = 24'hE280A0; rn = 3; end
            8:  begin nm = "sect";   nl = 4; rb = 24'hC2A7;   rn = 2; end
            9:  begin nm = "para";   nl = 4; rb = 24'hC2B6;   rn = 2; end
            10: begin nm = "prime";  nl = 5; rb = 24'hE280B2; rn = 3; end
            11: begin nm = "Prime";  nl = 5; rb = 24'hE280B3; rn = 3; end
            12: begin nm = "times";  nl = 5; rb = 24'hC397;   rn = 2; end
            13: begin nm = "minus";  nl = 5; rb = 24'hE28892; rn = 3; end
            14: begin nm = "middot"; nl = 6; rb = 24'hC2B7;   rn = 2; end
            15: begin nm = "lrm";    nl = 3; end
            16: begin nm = "rlm";    nl = 3; end
            17: begin nm = "amp";    nl = 3; end
            18: begin nm = "lt";     nl = 2; end
            19: begin nm = "gt";     nl = 2; end
            20: begin nm = "quot";   nl = 4; end
            default: begin nm = "apos"; nl = 4; end
        endcase
    endfunction

    function automatic bit held_equals(input logic [47:0] nm, input int nl);
        if (held_len != nl)
        begin
            return 1'b0;
        end
        for (int i = 0; i < nl; i++)
        begin
            if (held_name[i] != nm[8*(nl-1-i) +: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void add_step_byte(input logic [7:0] b);
        step_bytes = {step_bytes, b};
    endfunction

    function automatic void replay_held();
        add_step_byte(CH_AMP);
        for (int i = 0; i < held_len; i++)
        begin
            add_step_byte(held_name[i]);
        end
    endfunction

    function automatic void close_malformed();
        replay_held();
        entity_open = 1'b0;
        held_len = 0;
    endfunction

    function automatic void resolve_held();
        bit          verbatim;
        int          hit;
        logic [47:0] nm;
        int          nl;
        logic [23:0] rb;
        int          rn;
        int          hit_rn;
        logic [23:0] hit_rb;
        verbatim = held_len > 0 && held_name[0] == CH_HASH;
        hit = -1;
        hit_rn = 0;
        hit_rb = 24'h0;
        for (int k = 0; k < TABLE_ROWS; k++)
        begin
            entity_row(k, nm, nl, rb, rn);
            if (hit < 0 && held_equals(nm, nl))
            begin
                hit = k;
                hit_rb = rb;
                hit_rn = rn;
            end
        end
        if (hit >= REPLACED)
        begin
            verbatim = 1'b1;
        end
        if (verbatim)
        begin
            replay_held();
            add_step_byte(CH_SEMI);
        end
        else if (hit >= 0)
        begin
            for (int j = 0; j < hit_rn; j++)
            begin
                add_step_byte(hit_rb[8*(hit_rn-1-j) +: 8]);
            end
        end
        entity_open = 1'b0;
        held_len = 0;
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == CH_AMP)
        begin
            entity_open = 1'b1;
            held_len = 0;
        end
        else
        begin
            add_step_byte(b);
        end
    endfunction

    function automatic void predict_resolved(input logic [7:0] b, input logic stream_end);
        out_beat_t beat;
        step_bytes.delete();
        if (!entity_open)
        begin
            take_plain(b);
        end
        else if (b == CH_SEMI)
        begin
            resolve_held();
        end
        else if (b == CH_AMP || b == CH_LT || held_len >= MAX_NAME_BYTES)
        begin
            close_malformed();
            take_plain(b);
        end
        else
        begin
            held_name[held_len] = b;
            held_len++;
        end
        if (stream_end && entity_open)
        begin
            close_malformed();
        end
        for (int i = 0; i < step_bytes.size(); i++)
        begin
            beat.data = step_bytes[i];
            beat.last = (i == step_bytes.size() - 1);
            expected_beats = {expected_beats, beat};
        end
    endfunction

    function automatic logic [7:0] name_byte_random();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (b == CH_SEMI || b == CH_AMP || b == CH_LT);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic stream_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= stream_end;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_resolved(b, stream_end);
        n_in++;
    endtask

    task automatic send_text(input string s, input bit end_at_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], end_at_last && i == s.len() - 1);
        end
    endtask

    task automatic send_known_name(input int k, input int cut, input bit end_at_last);
        logic [47:0] nm;
        int          nl;
        logic [23:0] rb;
        int          rn;
        int          count;
        entity_row(k, nm, nl, rb, rn);
        count = (cut < nl) ? cut : nl;
        for (int i = 0; i < count; i++)
        begin
            send_byte(nm[8*(nl-1-i) +: 8], end_at_last && i == count - 1);
        end
    endtask

    task automatic send_random_name(input int count, input bit end_at_last);
        for (int i = 0; i < count; i++)
        begin
            send_byte(name_byte_random(), end_at_last && i == count - 1);
        end
    endtask

    task automatic drain_phase();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (n_out < expected_beats.size())
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_well_formed();
        int pick;
        pick = $urandom_range(9);
        send_byte(CH_AMP, 1'b0);
        if (pick < 6)
        begin
            send_known_name($urandom_range(TABLE_ROWS - 1), 8, 1'b0);
        end
        else if (pick < 8)
        begin
            send_byte(CH_HASH, 1'b0);
            send_random_name($urandom_range(5), 1'b0);
        end
        else
        begin
            send_random_name($urandom_range(7), 1'b0);
        end
        send_byte(CH_SEMI, $urandom_range(19) == 0);
    endtask

    task automatic send_broken();
        int          pick;
        int          k;
        logic [47:0] nm;
        int          nl;
        logic [23:0] rb;
        int          rn;
        pick = $urandom_range(5);
        k = $urandom_range(TABLE_ROWS - 1);
        send_byte(CH_AMP, 1'b0);
        case (pick)
            0:
            begin
                send_known_name(k, $urandom_range(6), 1'b0);
                send_byte(CH_AMP, 1'b0);
            end
            1:
            begin
                send_known_name(k, $urandom_range(6), 1'b0);
                send_byte(CH_LT, $urandom_range(3) == 0);
            end
            2:
            begin
                send_known_name(k, 8, 1'b1);
            end
            3:
            begin
                entity_row(k, nm, nl, rb, rn);
                send_byte(nm[8*(nl-1) +: 8] ^ 8'h20, 1'b0);
                for (int i = 1; i < nl; i++)
                begin
                    send_byte(nm[8*(nl-1-i) +: 8], 1'b0);
                end
                send_byte(CH_SEMI, 1'b0);
            end
            4:
            begin
                if ($urandom_range(1) == 0)
                begin
                    send_byte(CH_HASH, 1'b0);
                end
                send_random_name($urandom_range(MAX_NAME_BYTES + 2, MAX_NAME_BYTES - 2), 1'b0);
                send_byte(CH_SEMI, 1'b0);
            end
            default:
            begin
                send_known_name(k, $urandom_range(5), 1'b0);
                send_byte(CH_SEMI, 1'b0);
            end
        endcase
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("&;", 1'b0);
        send_text("&a<", 1'b0);
        send_text("&b&nbsp;", 1'b0);
        send_text("&#;", 1'b0);
        send_text("&", 1'b1);
        send_text("&q", 1'b1);
        send_text("&NBSP;", 1'b0);
        drain_phase();
    endtask

    task automatic test_name_limit();
        send_idle_pct = 0;
        recv_stall_pct = 76;
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_HASH, 1'b0);
        send_random_name(MAX_NAME_BYTES - 1, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_random_name(MAX_NAME_BYTES + 1, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_random_name(MAX_NAME_BYTES, 1'b1);
        drain_phase();
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct);
        int start;
        int pick;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        start = n_in;
        while (n_in - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_well_formed();
            end
            else if (pick < 85)
            begin
                send_byte(8'($urandom_range(255)), $urandom_range(29) == 0);
            end
            else
            begin
                send_broken();
            end
        end
        drain_phase();
    endtask

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (n_out >= expected_beats.size())
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected output transfer: byte %02h last %0b",
                             m_axis_tdata, m_axis_tlast);
                end
            end
            else
            begin
                want = expected_beats[n_out];
                if (want.data !== m_axis_tdata || want.last !== m_axis_tlast)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Output %0d mismatch: expected byte %02h last %0b, got %02h last %0b",
                                 n_out, want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            n_out++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int leftover;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_in = 0;
        entity_open = 1'b0;
        held_len = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_name_limit();
        test_random_traffic(0, 0);
        test_random_traffic(76, 0);
        test_random_traffic(0, 76);
        test_random_traffic(7, 7);

        leftover = expected_beats.size() - n_out;
        $display("Sent %0d input bytes and checked %0d output bytes: plain text, named, numeric,",
                 n_in, n_out);
        $display("unknown, malformed, overlong and stream-end entities under four handshake mixes.");
        if (mismatches == 0 && leftover == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
